// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the stack RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define BSIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define BSIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/bsir_pkg.sv =====
// Package for the bounded stack: command, status and state codes, field widths
// and the per-cell control bundle. No dependencies.
package bsir_pkg;

  localparam int CMD_W  = 3;
  localparam int WORD_W = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int OCC_W  = 5;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_LIST      = 3'd2,
    CMD_FIRST     = 3'd3,
    CMD_COUNT     = 3'd4,
    CMD_REMOVE_AT = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_BAD_POS = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic rd_hit;
  } cell_ctrl_t;

endpackage

// ===== rtl/bsir_cell.sv =====
// One storage cell of the stack chain: holds one entry, loads on push,
// takes its upper neighbor's entry on removal and drives the read chain.
// Depends on bsir_pkg.
module bsir_cell
  import bsir_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] up_data,
  input  logic [DATA_WIDTH-1:0] rd_in,
  output logic [DATA_WIDTH-1:0] data_q,
  output logic [DATA_WIDTH-1:0] rd_out
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = wr_data;
    end else if (ctrl.shift) begin
      data_nxt = up_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign rd_out = rd_in | (ctrl.rd_hit ? data_r : '0);

endmodule

// ===== rtl/bounded_stack_with_indexed_removal_core.sv =====
// Top level of the bounded stack with indexed removal.
// Depends on bsir_pkg, bsir_cell and assert_macros.svh.
//
// Usage:
// A command is taken at a rising edge where start is high and busy is low.
// in_command selects push, pop, list, first, count or remove_at; push stores
// in_entry_data, remove_at uses in_position. Each result is shown for one
// cycle with out_strobe high; the receiver cannot stall and must take it.
// Push, pop, first, count and remove_at give one result in the cycle after
// the command is taken, and a new command may be taken in every cycle.
// List on a non-empty stack raises busy while it reads out the held entries;
// its results, registered after the list state, appear in consecutive cycles,
// bottom entry first, out_last on the top entry. An empty list gives
// one result with status empty in the cycle after the command.
// The entries sit in a chain of cells; removal shifts all cells above the
// position down in the same cycle, so the list length alone sets busy time.
// The capacity register is written over cfg_valid/cfg_ready while no list is
// running. Synchronous reset empties the stack and sets the capacity to 16;
// stored words are not cleared and are only read after being pushed.
module bounded_stack_with_indexed_removal_core
  import bsir_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [WORD_W-1:0] in_entry_data,
  input  logic [POS_W-1:0]  in_position,
  output logic              out_strobe,
  output logic [STAT_W-1:0] out_status,
  output logic [WORD_W-1:0] out_data_out,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  `include "assert_macros.svh"

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW + 1 : POS_W + 1;
  localparam int XW   = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         list_idx_r, list_idx_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [CAP_W-1:0]      capacity_r;

  logic                  out_strobe_r, out_strobe_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [WORD_W-1:0]     out_data_r, out_data_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [OCC_W-1:0]      out_occ_r, out_occ_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  cmd_t                  cmd;
  logic                  empty;
  logic                  can_push;
  logic                  pos_ok;
  logic                  list_last;
  logic [CMPW-1:0]       cap_eff;
  logic [CMPW-1:0]       rd_addr;
  logic [XW-1:0]         in_ext;
  logic [XW-1:0]         rd_ext;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;

  cell_ctrl_t            ctrl [DEPTH];
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_chain [DEPTH+1];

  assign busy      = (state_r == ST_LIST);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign cmd       = cmd_t'(in_command);
  assign empty     = (fill_r == '0);

  assign cap_eff   = (CMPW'(capacity_r) < CMPW'(DEPTH)) ? CMPW'(capacity_r) : CMPW'(DEPTH);
  assign can_push  = (CMPW'(fill_r) < cap_eff);
  assign pos_ok    = (CMPW'(in_position) < CMPW'(fill_r));
  assign list_last = ((CMPW'(list_idx_r) + CMPW'(1)) == CMPW'(fill_r));

  assign in_ext  = XW'(in_entry_data);
  assign wr_data = in_ext[DATA_WIDTH-1:0];
  assign rd_data = rd_chain[0];
  assign rd_ext  = XW'(rd_data);

  always_comb begin
    rd_addr = CMPW'(in_position);
    if (state_r == ST_LIST) begin
      rd_addr = CMPW'(list_idx_r);
    end else begin
      case (cmd)
        CMD_POP:   rd_addr = CMPW'(fill_r) - CMPW'(1);
        CMD_FIRST: rd_addr = '0;
        default:   rd_addr = CMPW'(in_position);
      endcase
    end
  end

  assign rd_chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] up_data;

    if (i == DEPTH - 1) begin : g_top
      assign up_data = cell_q[i];
    end else begin : g_mid
      assign up_data = cell_q[i+1];
    end

    assign ctrl[i].load   = accept && (cmd == CMD_PUSH) && can_push &&
                            (CMPW'(fill_r) == CMPW'(i));
    assign ctrl[i].shift  = accept && (cmd == CMD_REMOVE_AT) && pos_ok &&
                            (CMPW'(i) >= CMPW'(in_position));
    assign ctrl[i].rd_hit = (rd_addr == CMPW'(i));

    bsir_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl[i]),
      .wr_data(wr_data),
      .up_data(up_data),
      .rd_in  (rd_chain[i+1]),
      .data_q (cell_q[i]),
      .rd_out (rd_chain[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      unique case (cmd)
        CMD_PUSH: begin
          if (can_push) begin
            fill_nxt = fill_r + CW'(1);
          end
        end
        CMD_POP: begin
          if (!empty) begin
            fill_nxt = fill_r - CW'(1);
          end
        end
        CMD_REMOVE_AT: begin
          if (pos_ok) begin
            fill_nxt = fill_r - CW'(1);
          end
        end
        default: fill_nxt = fill_r;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    list_idx_nxt = list_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        list_idx_nxt = '0;
        if (accept && (cmd == CMD_LIST) && !empty) begin
          state_nxt = ST_LIST;
        end
      end
      ST_LIST: begin
        list_idx_nxt = list_idx_r + AW'(1);
        if (list_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_strobe_nxt = 1'b0;
    out_status_nxt = STAT_OK;
    out_data_nxt   = '0;
    out_slot_nxt   = '0;
    out_occ_nxt    = OCC_W'(fill_nxt);
    out_last_nxt   = 1'b1;
    if (state_r == ST_LIST) begin
      out_strobe_nxt = 1'b1;
      out_data_nxt   = rd_ext[WORD_W-1:0];
      out_slot_nxt   = SLOT_W'(list_idx_r);
      out_last_nxt   = list_last;
    end else if (accept) begin
      out_strobe_nxt = 1'b1;
      unique case (cmd)
        CMD_PUSH: begin
          if (can_push) begin
            out_slot_nxt = SLOT_W'(fill_r);
          end else begin
            out_status_nxt = STAT_FULL;
          end
        end
        CMD_POP: begin
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            out_data_nxt = rd_ext[WORD_W-1:0];
            out_slot_nxt = SLOT_W'(fill_nxt);
          end
        end
        CMD_LIST: begin
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            out_strobe_nxt = 1'b0;
          end
        end
        CMD_FIRST: begin
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            out_data_nxt = rd_ext[WORD_W-1:0];
          end
        end
        CMD_COUNT: begin
          out_status_nxt = STAT_OK;
        end
        CMD_REMOVE_AT: begin
          if (pos_ok) begin
            out_data_nxt = rd_ext[WORD_W-1:0];
            out_slot_nxt = SLOT_W'(in_position);
          end else begin
            out_status_nxt = STAT_BAD_POS;
          end
        end
        default: out_strobe_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      list_idx_r   <= '0;
      fill_r       <= '0;
      capacity_r   <= CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      list_idx_r   <= list_idx_nxt;
      fill_r       <= fill_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_slot_r   <= out_slot_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_data_out   = out_data_r;
  assign out_slot_index = out_slot_r;
  assign out_occupancy  = out_occ_r;
  assign out_last       = out_last_r;

  `BSIR_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (state_r == ST_IDLE) && (fill_r == '0), "Reset did not empty the stack.")
  `BSIR_ASSERT(a_fill_bound, CMPW'(fill_r) <= CMPW'(DEPTH), "Fill count exceeds the stack depth.")
  `BSIR_ASSERT(a_list_idx_range, (state_r == ST_LIST) |-> (CMPW'(list_idx_r) < CMPW'(fill_r)), "List index is beyond the held entries.")
  `BSIR_ASSERT(a_list_emits, (state_r == ST_LIST) |=> out_strobe_r, "A list cycle gave no result.")
  `BSIR_ASSERT(a_push_effect, (accept && (cmd == CMD_PUSH)) |=> out_strobe_r && (((out_status_r == STAT_OK) && (fill_r == $past(fill_r) + 1'b1)) || ((out_status_r == STAT_FULL) && (fill_r == $past(fill_r)))), "Push transaction result disagrees with the fill count.")

endmodule

// ===== test/tb_bounded_stack_with_indexed_removal_core.sv =====
// Self-checking testbench for bounded_stack_with_indexed_removal_core.
// Uses bsir_pkg for codes and widths; a shadow stack predicts every result, including
// the list streams, over several capacity settings with random start gaps.
`timescale 1ns / 100ps

module tb_bounded_stack_with_indexed_removal_core;
  import bsir_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 41;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0]  position;
  } stack_request_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] data;
    logic [SLOT_W-1:0] slot;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } stack_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  in_command = '0;
  logic [WORD_W-1:0] in_entry_data = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [WORD_W-1:0] out_data_out;
  logic [SLOT_W-1:0] out_slot_index;
  logic [OCC_W-1:0]  out_occupancy;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data = '0;

  stack_request_t    pending_requests[$];
  stack_reply_t      replies_due[$];
  stack_reply_t      due;
  logic [WORD_W-1:0] shadow_words[DEPTH];
  int                shadow_fill = 0;
  int                shadow_cap = CAP_RESET;
  logic              took = 1'b0;
  bit                holding = 1'b0;
  bit                no_idle = 1'b0;
  int                gap_left = 0;
  int                error_count = 0;

  bounded_stack_with_indexed_removal_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_entry_data  (in_entry_data),
    .in_position    (in_position),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_slot_index (out_slot_index),
    .out_occupancy  (out_occupancy),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic due_reply(input logic [STAT_W-1:0] st, input logic [WORD_W-1:0] data,
                           input int slot, input int occ, input logic last);
    stack_reply_t r;
    r.status = st;
    r.data = data;
    r.slot = slot[SLOT_W-1:0];
    r.occupancy = occ[OCC_W-1:0];
    r.last = last;
    replies_due.push_back(r);
  endtask

  task automatic apply_to_shadow(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                                 input logic [POS_W-1:0] pos);
    int limit;
    logic [WORD_W-1:0] taken;
    limit = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_fill < limit) begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
          due_reply(STAT_OK, '0, shadow_fill - 1, shadow_fill, 1'b1);
        end else begin
          due_reply(STAT_FULL, '0, 0, shadow_fill, 1'b1);
        end
      end
      CMD_POP: begin
        if (shadow_fill == 0) begin
          due_reply(STAT_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          shadow_fill--;
          due_reply(STAT_OK, shadow_words[shadow_fill], shadow_fill, shadow_fill, 1'b1);
        end
      end
      CMD_LIST: begin
        if (shadow_fill == 0) begin
          due_reply(STAT_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++) begin
            due_reply(STAT_OK, shadow_words[i], i, shadow_fill, i + 1 == shadow_fill);
          end
        end
      end
      CMD_FIRST: begin
        if (shadow_fill == 0) begin
          due_reply(STAT_EMPTY, '0, 0, 0, 1'b1);
        end else begin
          due_reply(STAT_OK, shadow_words[0], 0, shadow_fill, 1'b1);
        end
      end
      CMD_COUNT: due_reply(STAT_OK, '0, 0, shadow_fill, 1'b1);
      CMD_REMOVE_AT: begin
        if (int'(pos) >= shadow_fill) begin
          due_reply(STAT_BAD_POS, '0, 0, shadow_fill, 1'b1);
        end else begin
          taken = shadow_words[pos[SLOT_W-1:0]];
          for (int i = pos; i + 1 < shadow_fill; i++) begin
            shadow_words[i] = shadow_words[i + 1];
          end
          shadow_fill--;
          due_reply(STAT_OK, taken, pos, shadow_fill, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Results are compared before the transaction of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      shadow_cap = CAP_RESET;
      replies_due.delete();
      took <= 1'b0;
    end else begin
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          error_count++;
          $display("%0t: result mismatch, expected none, actual status %0d data %h",
                   $time, out_status, out_data_out);
        end else begin
          due = replies_due.pop_front();
          check_field("status", due.status, out_status);
          check_field("data_out", due.data, out_data_out);
          check_field("slot_index", due.slot, out_slot_index);
          check_field("occupancy", due.occupancy, out_occupancy);
          check_field("last", due.last, out_last);
        end
      end
      if (start && !busy) begin
        apply_to_shadow(in_command, in_entry_data, in_position);
      end
      if (cfg_valid && cfg_ready) begin
        shadow_cap = cfg_data;
      end
      took <= start && !busy;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          stack_request_t req;
          req = pending_requests.pop_front();
          in_command <= req.command;
          in_entry_data <= req.word;
          in_position <= req.position;
          start <= 1'b1;
          holding = 1'b1;
          gap_left = idle_span();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                             input logic [POS_W-1:0] pos);
    stack_request_t req;
    req.command = cmd;
    req.word = word;
    req.position = pos;
    pending_requests.push_back(req);
  endtask

  task automatic add_random_request(input int push_pct);
    int r;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      cmd = CMD_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) cmd = CMD_POP;
      else if (r < 38) cmd = CMD_LIST;
      else if (r < 48) cmd = CMD_FIRST;
      else if (r < 58) cmd = CMD_COUNT;
      else if (r < 95) cmd = CMD_REMOVE_AT;
      else cmd = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    end
    if ($urandom_range(0, 3) == 0) begin
      pos = POS_W'($urandom_range(0, 63));
    end else begin
      pos = POS_W'($urandom_range(0, 15));
    end
    add_request(cmd, $urandom, pos);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_requests.size() > 0 || holding || replies_due.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase_cap[PHASES];
    int phase_push[PHASES];
    phase_cap = '{31, 3, 16, 0, 8, 16};
    phase_push = '{80, 40, 50, 30, 55, 50};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_request(CMD_POP, 32'h0, 6'd0);
    add_request(CMD_LIST, 32'h0, 6'd0);
    add_request(CMD_FIRST, 32'h0, 6'd0);
    add_request(CMD_COUNT, 32'h0, 6'd0);
    add_request(CMD_REMOVE_AT, 32'h0, 6'd0);
    add_request(CMD_PUSH, 32'h0000_0000, 6'd0);
    add_request(CMD_PUSH, 32'hFFFF_FFFF, 6'd63);
    add_request(CMD_PUSH, 32'h1234_5678, 6'd0);
    add_request(CMD_PUSH, 32'hA5A5_A5A5, 6'd0);
    add_request(CMD_LIST, 32'hFFFF_FFFF, 6'd63);
    add_request(CMD_FIRST, 32'h0, 6'd0);
    add_request(CMD_COUNT, 32'h0, 6'd0);
    add_request(CMD_REMOVE_AT, 32'h0, 6'd63);
    add_request(CMD_REMOVE_AT, 32'h0, 6'd4);
    add_request(CMD_REMOVE_AT, 32'h0, 6'd1);
    add_request(CMD_REMOVE_AT, 32'h0, 6'd2);
    add_request(CMD_UNUSED_6, 32'hFFFF_FFFF, 6'd63);
    add_request(CMD_UNUSED_7, 32'h0, 6'd0);
    add_request(CMD_POP, 32'h0, 6'd0);
    add_request(CMD_POP, 32'h0, 6'd0);
    add_request(CMD_POP, 32'h0, 6'd0);
    wait_drained();

    write_capacity(5'd1);
    add_request(CMD_PUSH, 32'h0000_FFFF, 6'd0);
    add_request(CMD_PUSH, 32'hFFFF_0000, 6'd0);
    wait_drained();

    write_capacity(5'd0);
    add_request(CMD_PUSH, 32'h5A5A_5A5A, 6'd0);
    add_request(CMD_COUNT, 32'h0, 6'd0);
    wait_drained();

    // Capacity settings above the stack depth and below the current fill are both covered.
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(CAP_W'(phase_cap[p]));
      no_idle = (p == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        add_random_request(phase_push[p]);
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
